### hw/rtl/htok_pkg.sv
package htok_pkg;

  // Parser phase
  typedef enum logic [3:0] {
    PH_METHOD   = 4'd0,
    PH_PRE_URI  = 4'd1,
    PH_URI      = 4'd2,
    PH_PKEY     = 4'd3,
    PH_PVAL     = 4'd4,
    PH_PRE_VER  = 4'd5,
    PH_VERSION  = 4'd6,
    PH_TAIL     = 4'd7,
    PH_HSTART   = 4'd8,
    PH_HNAME    = 4'd9,
    PH_HPRE     = 4'd10,
    PH_HVAL     = 4'd11,
    PH_BODY     = 4'd12,
    PH_HALT     = 4'd13
  } phase_t;

  // Token kinds on the result channel
  typedef enum logic [3:0] {
    K_METHOD    = 4'd0,
    K_URI       = 4'd1,
    K_KEY       = 4'd2,
    K_VAL_START = 4'd3,
    K_VALUE     = 4'd4,
    K_PAIR_END  = 4'd5,
    K_PAR_ABORT = 4'd6,
    K_VERSION   = 4'd7,
    K_HDR_NAME  = 4'd8,
    K_HDR_VALUE = 4'd9,
    K_HDR_END   = 4'd10,
    K_HDR_BAD   = 4'd11,
    K_HEAD_END  = 4'd12,
    K_BODY      = 4'd13,
    K_ERROR     = 4'd14
  } kind_t;

  localparam int unsigned NUM_VERBS = 8;
  localparam logic [3:0]  VERB_UNKNOWN = 4'd8;

  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;

  // Verb spellings, zero padded; verb code is the row index
  localparam logic [7:0] VERB_TEXT [0:7][0:7] = '{
    '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "E", "A", "D",   8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "O", "S", "T",   8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E",   "T",   "E",   8'h00, 8'h00},
    '{"C", "O", "N", "N",   "E",   "C",   "T",   8'h00},
    '{"O", "P", "T", "I",   "O",   "N",   "S",   8'h00},
    '{"T", "R", "A", "C",   "E",   8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] VERB_LEN [0:7] = '{
    3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd7, 3'd7, 3'd5
  };

  // Architectural state of the tokenizer
  typedef struct packed {
    phase_t     phase;
    logic [7:0] verb_match;
    logic [2:0] verb_pos;
    logic [1:0] esc_cnt;
    logic [3:0] esc_high;
    logic       pair_open;
    logic       params_stopped;
    logic       cr_pending;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:          PH_METHOD,
    verb_match:     8'hFF,
    verb_pos:       3'd0,
    esc_cnt:        2'd0,
    esc_high:       4'd0,
    pair_open:      1'b0,
    params_stopped: 1'b0,
    cr_pending:     1'b0
  };

  // One token between the step logic and the output register
  typedef struct packed {
    logic       vld;
    kind_t      kind;
    logic [7:0] data;
  } tok_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b inside {8'h20, [8'h09:8'h0D]});
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {["0":"9"]})      r = {1'b1, 4'(b - 8'h30)};
    else if (b inside {["A":"F"]}) r = {1'b1, 4'(b - 8'h37)};
    else if (b inside {["a":"f"]}) r = {1'b1, 4'(b - 8'h57)};
    return r;
  endfunction

endpackage

### hw/rtl/htok_step.sv
module htok_step
  import htok_pkg::*;
(
  input  state_t     st,
  input  logic [7:0] byte_in,
  input  logic       restart,
  output state_t     st_nxt,
  output tok_t       tok
);

  state_t     s;
  state_t     n;
  tok_t       t;
  logic [7:0] b;
  logic       ws;
  logic       bad_ctl;
  logic [4:0] hx;
  kind_t      vkind;
  logic [3:0] code;

  // Token helpers write into t/n; kept as plain comb logic below

  always_comb begin
    s       = restart ? STATE_RESET : st;
    n       = s;
    b       = byte_in;
    ws      = is_ws(b);
    bad_ctl = (b == CH_CR) || (b == CH_NUL);
    hx      = hex_val(b);
    vkind   = (s.phase == PH_PKEY) ? K_KEY : K_VALUE;
    t       = '{vld: 1'b0, kind: K_ERROR, data: 8'h00};

    // Method match: first surviving verb whose full text was seen
    code = VERB_UNKNOWN;
    for (int i = NUM_VERBS - 1; i >= 0; i--) begin
      if (s.verb_match[i] && (VERB_LEN[i] <= s.verb_pos)) code = 4'(i);
    end

    case (s.phase)
      PH_METHOD: begin
        if (bad_ctl) begin
          n.phase = PH_HALT;
          t = '{vld: 1'b1, kind: K_ERROR, data: 8'h00};
        end else if (ws) begin
          n.phase = PH_PRE_URI;
          t = '{vld: 1'b1, kind: K_METHOD, data: {4'd0, code}};
        end else begin
          for (int i = 0; i < NUM_VERBS; i++) begin
            if ((VERB_LEN[i] > s.verb_pos) && (VERB_TEXT[i][s.verb_pos] != b))
              n.verb_match[i] = 1'b0;
          end
          if (s.verb_pos != 3'd7) n.verb_pos = s.verb_pos + 3'd1;
        end
      end

      PH_PRE_URI, PH_URI: begin
        if (bad_ctl) begin
          n.phase = PH_HALT;
          t = '{vld: 1'b1, kind: K_ERROR, data: 8'h00};
        end else if (ws) begin
          if (s.phase == PH_URI) n.phase = PH_PRE_VER;
        end else if (b == CH_QUEST) begin
          n.phase = PH_PKEY;
        end else begin
          n.phase = PH_URI;
          t = '{vld: 1'b1, kind: K_URI, data: b};
        end
      end

      PH_PKEY, PH_PVAL: begin
        if (bad_ctl) begin
          n.phase = PH_HALT;
          t = '{vld: 1'b1, kind: K_ERROR, data: 8'h00};
        end else if (ws) begin
          // end of query closes a pending escape or open pair
          if (!s.params_stopped) begin
            if (s.esc_cnt != 2'd0)
              t = '{vld: 1'b1, kind: K_PAR_ABORT, data: 8'h00};
            else if (s.pair_open)
              t = '{vld: 1'b1, kind: K_PAIR_END, data: 8'h00};
          end
          n.esc_cnt   = 2'd0;
          n.pair_open = 1'b0;
          n.phase     = PH_PRE_VER;
        end else if (s.params_stopped) begin
          // rest of query dropped
        end else if (s.esc_cnt != 2'd0) begin
          if (!hx[4]) begin
            n.params_stopped = 1'b1;
            n.esc_cnt        = 2'd0;
            n.pair_open      = 1'b0;
            t = '{vld: 1'b1, kind: K_PAR_ABORT, data: 8'h00};
          end else if (s.esc_cnt == 2'd1) begin
            n.esc_high = hx[3:0];
            n.esc_cnt  = 2'd2;
          end else begin
            n.esc_cnt = 2'd0;
            t = '{vld: 1'b1, kind: vkind, data: {s.esc_high, hx[3:0]}};
          end
        end else if (b == CH_PERCENT) begin
          n.esc_cnt   = 2'd1;
          n.pair_open = 1'b1;
        end else if (b == CH_AMP) begin
          n.pair_open = 1'b0;
          n.phase     = PH_PKEY;
          t = '{vld: 1'b1, kind: K_PAIR_END, data: 8'h00};
        end else begin
          n.pair_open = 1'b1;
          if ((b == CH_EQUAL) && (s.phase == PH_PKEY)) begin
            n.phase = PH_PVAL;
            t = '{vld: 1'b1, kind: K_VAL_START, data: 8'h00};
          end else begin
            t = '{vld: 1'b1, kind: vkind, data: b};
          end
        end
      end

      PH_PRE_VER: begin
        if (bad_ctl) begin
          n.phase = PH_HALT;
          t = '{vld: 1'b1, kind: K_ERROR, data: 8'h00};
        end else if (!ws) begin
          n.phase = PH_VERSION;
          t = '{vld: 1'b1, kind: K_VERSION, data: b};
        end
      end

      PH_VERSION: begin
        if (b == CH_NUL) begin
          n.phase = PH_HALT;
          t = '{vld: 1'b1, kind: K_ERROR, data: 8'h00};
        end else if (b == CH_CR) begin
          n.phase      = PH_TAIL;
          n.cr_pending = 1'b1;
        end else begin
          t = '{vld: 1'b1, kind: K_VERSION, data: b};
        end
      end

      // skip to end of line
      PH_TAIL: begin
        if (s.cr_pending && (b == CH_LF)) begin
          n.phase      = PH_HSTART;
          n.cr_pending = 1'b0;
        end else begin
          n.cr_pending = (b == CH_CR);
        end
      end

      PH_HSTART, PH_HNAME: begin
        if ((s.phase == PH_HSTART) && s.cr_pending) begin
          if (b == CH_LF) begin
            n.cr_pending = 1'b0;
            n.phase      = PH_BODY;
            t = '{vld: 1'b1, kind: K_HEAD_END, data: 8'h00};
          end else begin
            // a second CR may still start the CR LF that ends this line
            n.phase      = PH_TAIL;
            n.cr_pending = (b == CH_CR);
            t = '{vld: 1'b1, kind: K_HDR_BAD, data: 8'h00};
          end
        end else if ((s.phase == PH_HSTART) && (b == CH_CR)) begin
          n.cr_pending = 1'b1;
        end else if (b == CH_COLON) begin
          n.phase = PH_HPRE;
        end else if (bad_ctl) begin
          n.phase      = PH_TAIL;
          n.cr_pending = (b == CH_CR);
          t = '{vld: 1'b1, kind: K_HDR_BAD, data: 8'h00};
        end else begin
          n.phase = PH_HNAME;
          t = '{vld: 1'b1, kind: K_HDR_NAME, data: b};
        end
      end

      PH_HPRE: begin
        if (bad_ctl) begin
          n.phase      = PH_TAIL;
          n.cr_pending = (b == CH_CR);
          t = '{vld: 1'b1, kind: K_HDR_BAD, data: 8'h00};
        end else if (!ws) begin
          n.phase = PH_HVAL;
          t = '{vld: 1'b1, kind: K_HDR_VALUE, data: b};
        end
      end

      PH_HVAL: begin
        if (b == CH_NUL) begin
          n.phase      = PH_TAIL;
          n.cr_pending = 1'b0;
          t = '{vld: 1'b1, kind: K_HDR_BAD, data: 8'h00};
        end else if (b == CH_CR) begin
          n.phase      = PH_TAIL;
          n.cr_pending = 1'b1;
          t = '{vld: 1'b1, kind: K_HDR_END, data: 8'h00};
        end else begin
          t = '{vld: 1'b1, kind: K_HDR_VALUE, data: b};
        end
      end

      PH_BODY: begin
        t = '{vld: 1'b1, kind: K_BODY, data: b};
      end

      default: begin
        // halted: wait for restart
      end
    endcase

    st_nxt = n;
    tok    = t;
  end

endmodule

### hw/rtl/htok_out_reg.sv
module htok_out_reg
  import htok_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,       // a word was accepted this cycle
  input  tok_t       tok,
  output logic       can_load,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic [3:0] out_tuser
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] data_r;
  kind_t      kind_r;

  // slot is free when empty or draining this cycle
  assign can_load = !vld_r || out_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (out_tready) vld_nxt = 1'b0;
    if (load && tok.vld) vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load && tok.vld) begin
      data_r <= tok.data;
      kind_r <= tok.kind;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;

endmodule

### hw/rtl/http_request_head_tokenizer_unit.sv
// HTTP request head tokenizer. Takes one request byte per word on the in_
// stream (tuser = restart, which clears the parser before that byte) and
// emits at most one token per byte on the out_ stream, in byte order: method
// code, URI bytes, query keys/values (%xx decoded), version, header names and
// values, header end/bad markers, head end, then body bytes. A request-line
// fault gives an error token and the parser then drops bytes until restart.
// Throughput is one byte per clock: the parse step is combinational and the
// result sits in one output register, so a new byte is taken whenever that
// register is empty or is being read in the same cycle. A byte's token is
// valid in the cycle after the byte is accepted.
module http_request_head_tokenizer_unit
  import htok_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] byte_in
  input  logic       in_tuser,    // [0] restart
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] data
  output logic [3:0] out_tuser    // [3:0] kind
);

  state_t st_r;
  state_t st_nxt;
  tok_t   tok;
  logic   acc;

  assign acc = in_tvalid && in_tready;

  // per-byte parse step
  htok_step u_step (
    .st      (st_r),
    .byte_in (in_tdata),
    .restart (in_tuser),
    .st_nxt  (st_nxt),
    .tok     (tok)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (acc) begin
      st_r <= st_nxt;
    end
  end

  // result register
  htok_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (acc),
    .tok        (tok),
    .can_load   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
